>>> hw/rtl/dsp_mailbox_dma_registers_top_assert.svh
// Assertion macros for the mailbox and DMA register block.
`ifndef DSP_MAILBOX_DMA_REGISTERS_TOP_ASSERT_SVH
`define DSP_MAILBOX_DMA_REGISTERS_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DSPMB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("register block check failed");

// Check that cons holds in the cycle after ante.
`define DSPMB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("register block check failed");

`endif

>>> hw/rtl/dspmb_pkg.sv
// Package with access codes, register selects, masks and the result type.
package dspmb_pkg;

    localparam int KIND_W = 2;
    localparam int SEL_W  = 4;
    localparam int DATA_W = 16;
    localparam int HIGH_W = 10;
    localparam int MAIN_W = HIGH_W + DATA_W;
    localparam int CTRL_W = 2;

    // Access kinds
    localparam logic [KIND_W-1:0] KIND_DSP_RD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DSP_WR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CPU_RD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CPU_WR = 2'd3;

    // DSP side register selects
    localparam logic [SEL_W-1:0] DSP_DMAHI   = 4'd0;
    localparam logic [SEL_W-1:0] DSP_DMALO   = 4'd1;
    localparam logic [SEL_W-1:0] DSP_DSPADDR = 4'd2;
    localparam logic [SEL_W-1:0] DSP_CTRL    = 4'd3;
    localparam logic [SEL_W-1:0] DSP_LEN     = 4'd4;
    localparam logic [SEL_W-1:0] DSP_CMBH    = 4'd5;
    localparam logic [SEL_W-1:0] DSP_CMBL    = 4'd6;
    localparam logic [SEL_W-1:0] DSP_DMBH    = 4'd7;
    localparam logic [SEL_W-1:0] DSP_DMBL    = 4'd8;
    localparam logic [SEL_W-1:0] DSP_IRQ     = 4'd9;
    localparam logic [SEL_W-1:0] DSP_IGNORED = 4'd10;

    // CPU side register selects
    localparam logic [SEL_W-1:0] CPU_CMBH = 4'd0;
    localparam logic [SEL_W-1:0] CPU_CMBL = 4'd1;
    localparam logic [SEL_W-1:0] CPU_DMBH = 4'd2;
    localparam logic [SEL_W-1:0] CPU_DMBL = 4'd3;

    // Write masks and the mailbox full flag
    localparam logic [HIGH_W-1:0] MAIN_HIGH_MASK = 10'h3ff;
    localparam logic [DATA_W-1:0] WORD_MASK      = 16'hfffc;
    localparam logic [DATA_W-1:0] HALF_MASK      = 16'hfffe;
    localparam logic [CTRL_W-1:0] CTRL_MASK      = 2'h3;
    localparam logic [DATA_W-1:0] FULL_FLAG      = 16'h8000;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_error;
        logic              dma_start;
        logic [MAIN_W-1:0] dma_main_address;
        logic [DATA_W-1:0] dma_local_address;
        logic [DATA_W-1:0] dma_length;
        logic              dma_to_main;
        logic              dma_instruction_mem;
        logic              irq_pulse;
    } rsp_t;

endpackage

>>> hw/rtl/dspmb_req_if.sv
// Request channel interface: one register access per beat.
interface dspmb_req_if;
    logic                       valid;
    logic                       ready;
    logic [dspmb_pkg::KIND_W-1:0] kind;
    logic [dspmb_pkg::SEL_W-1:0]  reg_select;
    logic [dspmb_pkg::DATA_W-1:0] write_data;

    modport source (output valid, output kind, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input reg_select, input write_data,
                    output ready);
endinterface

>>> hw/rtl/dspmb_rsp_if.sv
// Result channel interface: one access result per beat.
interface dspmb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [dspmb_pkg::DATA_W-1:0] read_data;
    logic                         access_error;
    logic                         dma_start;
    logic [dspmb_pkg::MAIN_W-1:0] dma_main_address;
    logic [dspmb_pkg::DATA_W-1:0] dma_local_address;
    logic [dspmb_pkg::DATA_W-1:0] dma_length;
    logic                         dma_to_main;
    logic                         dma_instruction_mem;
    logic                         irq_pulse;

    modport source (output valid, output read_data, output access_error, output dma_start,
                    output dma_main_address, output dma_local_address, output dma_length,
                    output dma_to_main, output dma_instruction_mem, output irq_pulse,
                    input ready);
    modport sink   (input valid, input read_data, input access_error, input dma_start,
                    input dma_main_address, input dma_local_address, input dma_length,
                    input dma_to_main, input dma_instruction_mem, input irq_pulse,
                    output ready);
endinterface

>>> hw/rtl/dsp_mailbox_dma_registers_top.sv
// Top level of the host/DSP mailbox and DMA register block.
//
// Each request beat is one register access (DSP or CPU, read or write). The
// block decodes it, updates the mailbox and DMA registers, and places one
// result beat in an output register on the next cycle. Throughput is one
// access per clock: the input is ready whenever the output register is empty
// or is being taken in the same cycle, so a stalled result holds the input
// for exactly as long as it stalls. The DMA fields of each result show the
// register state after that access; dma_start and irq_pulse are set only
// on the result of the access that caused them.
`include "dsp_mailbox_dma_registers_top_assert.svh"

module dsp_mailbox_dma_registers_top (
    input  logic         clk,
    input  logic         rst_n,
    dspmb_req_if.sink    req,
    dspmb_rsp_if.source  rsp
);

    // DMA registers
    logic [dspmb_pkg::HIGH_W-1:0] main_addr_high_reg, main_addr_high_next;
    logic [dspmb_pkg::DATA_W-1:0] main_addr_low_reg,  main_addr_low_next;
    logic [dspmb_pkg::DATA_W-1:0] local_addr_reg,     local_addr_next;
    logic [dspmb_pkg::CTRL_W-1:0] dma_control_reg,    dma_control_next;
    logic [dspmb_pkg::DATA_W-1:0] transfer_length_reg, transfer_length_next;

    // Mailboxes: inbox is CPU to DSP, outbox is DSP to CPU
    logic [dspmb_pkg::DATA_W-1:0] inbox_high_shadow_reg,  inbox_high_shadow_next;
    logic [dspmb_pkg::DATA_W-1:0] inbox_high_reg,         inbox_high_next;
    logic [dspmb_pkg::DATA_W-1:0] inbox_low_reg,          inbox_low_next;
    logic [dspmb_pkg::DATA_W-1:0] outbox_high_shadow_reg, outbox_high_shadow_next;
    logic [dspmb_pkg::DATA_W-1:0] outbox_high_reg,        outbox_high_next;
    logic [dspmb_pkg::DATA_W-1:0] outbox_low_reg,         outbox_low_next;

    // Output register
    logic              out_valid_reg;
    dspmb_pkg::rsp_t   rsp_reg;
    dspmb_pkg::rsp_t   rsp_next;

    logic accept;

    // Take a new beat when the output register is empty or drains this cycle.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        logic [dspmb_pkg::DATA_W-1:0] rd;
        logic                         err;
        logic                         start;
        logic                         irq;

        rd    = '0;
        err   = 1'b0;
        start = 1'b0;
        irq   = 1'b0;

        // Hold everything by default.
        main_addr_high_next     = main_addr_high_reg;
        main_addr_low_next      = main_addr_low_reg;
        local_addr_next         = local_addr_reg;
        dma_control_next        = dma_control_reg;
        transfer_length_next    = transfer_length_reg;
        inbox_high_shadow_next  = inbox_high_shadow_reg;
        inbox_high_next         = inbox_high_reg;
        inbox_low_next          = inbox_low_reg;
        outbox_high_shadow_next = outbox_high_shadow_reg;
        outbox_high_next        = outbox_high_reg;
        outbox_low_next         = outbox_low_reg;

        case (req.kind)
            dspmb_pkg::KIND_DSP_RD:
            begin
                case (req.reg_select)
                    dspmb_pkg::DSP_DMAHI:   rd = {{(dspmb_pkg::DATA_W-dspmb_pkg::HIGH_W){1'b0}},
                                                  main_addr_high_reg};
                    dspmb_pkg::DSP_DMALO:   rd = main_addr_low_reg;
                    dspmb_pkg::DSP_DSPADDR: rd = local_addr_reg;
                    dspmb_pkg::DSP_CTRL:    rd = {{(dspmb_pkg::DATA_W-dspmb_pkg::CTRL_W){1'b0}},
                                                  dma_control_reg};
                    dspmb_pkg::DSP_LEN:     rd = transfer_length_reg;
                    dspmb_pkg::DSP_CMBH:    rd = inbox_high_reg;
                    dspmb_pkg::DSP_CMBL:
                    begin
                        // Receiver reads the low half: drop the full flag.
                        rd              = inbox_low_reg;
                        inbox_high_next = inbox_high_reg & ~dspmb_pkg::FULL_FLAG;
                    end
                    dspmb_pkg::DSP_DMBH:    rd = outbox_high_reg;
                    dspmb_pkg::DSP_DMBL:
                    begin
                        rd               = outbox_low_reg;
                        outbox_high_next = outbox_high_reg & ~dspmb_pkg::FULL_FLAG;
                    end
                    dspmb_pkg::DSP_IRQ:     rd = '0;
                    default:                err = 1'b1;
                endcase
            end
            dspmb_pkg::KIND_DSP_WR:
            begin
                case (req.reg_select)
                    dspmb_pkg::DSP_DMAHI:
                        main_addr_high_next = req.write_data[dspmb_pkg::HIGH_W-1:0]
                                              & dspmb_pkg::MAIN_HIGH_MASK;
                    dspmb_pkg::DSP_DMALO:
                        main_addr_low_next = req.write_data & dspmb_pkg::WORD_MASK;
                    dspmb_pkg::DSP_DSPADDR:
                        local_addr_next = req.write_data & dspmb_pkg::HALF_MASK;
                    dspmb_pkg::DSP_CTRL:
                        dma_control_next = req.write_data[dspmb_pkg::CTRL_W-1:0]
                                           & dspmb_pkg::CTRL_MASK;
                    dspmb_pkg::DSP_LEN:
                    begin
                        transfer_length_next = req.write_data & dspmb_pkg::WORD_MASK;
                        start                = 1'b1;
                    end
                    dspmb_pkg::DSP_CMBH, dspmb_pkg::DSP_CMBL:
                        err = 1'b1;
                    dspmb_pkg::DSP_DMBH:
                        outbox_high_shadow_next = req.write_data;
                    dspmb_pkg::DSP_DMBL:
                    begin
                        // Commit the shadow with the full flag.
                        outbox_low_next  = req.write_data;
                        outbox_high_next = outbox_high_shadow_reg | dspmb_pkg::FULL_FLAG;
                    end
                    dspmb_pkg::DSP_IRQ:
                        irq = req.write_data[0];
                    dspmb_pkg::DSP_IGNORED:
                        ;
                    default:
                        err = 1'b1;
                endcase
            end
            dspmb_pkg::KIND_CPU_RD:
            begin
                case (req.reg_select)
                    dspmb_pkg::CPU_CMBH: rd = inbox_high_reg;
                    dspmb_pkg::CPU_CMBL: rd = inbox_low_reg;
                    dspmb_pkg::CPU_DMBH: rd = outbox_high_reg;
                    dspmb_pkg::CPU_DMBL:
                    begin
                        rd               = outbox_low_reg;
                        outbox_high_next = outbox_high_reg & ~dspmb_pkg::FULL_FLAG;
                    end
                    default:             err = 1'b1;
                endcase
            end
            default:
            begin
                // CPU write
                case (req.reg_select)
                    dspmb_pkg::CPU_CMBH:
                        inbox_high_shadow_next = req.write_data;
                    dspmb_pkg::CPU_CMBL:
                    begin
                        inbox_low_next  = req.write_data;
                        inbox_high_next = inbox_high_shadow_reg | dspmb_pkg::FULL_FLAG;
                    end
                    default:
                        err = 1'b1;
                endcase
            end
        endcase

        rsp_next.read_data           = rd;
        rsp_next.access_error        = err;
        rsp_next.dma_start           = start;
        rsp_next.dma_main_address    = {main_addr_high_next, main_addr_low_next};
        rsp_next.dma_local_address   = local_addr_next;
        rsp_next.dma_length          = transfer_length_next;
        rsp_next.dma_to_main         = dma_control_next[0];
        rsp_next.dma_instruction_mem = dma_control_next[1];
        rsp_next.irq_pulse           = irq;
    end

    // Register state; the mailbox and DMA registers advance only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_addr_high_reg     <= '0;
            main_addr_low_reg      <= '0;
            local_addr_reg         <= '0;
            dma_control_reg        <= '0;
            transfer_length_reg    <= '0;
            inbox_high_shadow_reg  <= '0;
            inbox_high_reg         <= '0;
            inbox_low_reg          <= '0;
            outbox_high_shadow_reg <= '0;
            outbox_high_reg        <= '0;
            outbox_low_reg         <= '0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                main_addr_high_reg     <= main_addr_high_next;
                main_addr_low_reg      <= main_addr_low_next;
                local_addr_reg         <= local_addr_next;
                dma_control_reg        <= dma_control_next;
                transfer_length_reg    <= transfer_length_next;
                inbox_high_shadow_reg  <= inbox_high_shadow_next;
                inbox_high_reg         <= inbox_high_next;
                inbox_low_reg          <= inbox_low_next;
                outbox_high_shadow_reg <= outbox_high_shadow_next;
                outbox_high_reg        <= outbox_high_next;
                outbox_low_reg         <= outbox_low_next;
                out_valid_reg          <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; load with each accepted beat, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.read_data           = rsp_reg.read_data;
    assign rsp.access_error        = rsp_reg.access_error;
    assign rsp.dma_start           = rsp_reg.dma_start;
    assign rsp.dma_main_address    = rsp_reg.dma_main_address;
    assign rsp.dma_local_address   = rsp_reg.dma_local_address;
    assign rsp.dma_length          = rsp_reg.dma_length;
    assign rsp.dma_to_main         = rsp_reg.dma_to_main;
    assign rsp.dma_instruction_mem = rsp_reg.dma_instruction_mem;
    assign rsp.irq_pulse           = rsp_reg.irq_pulse;

    // A DSP length write yields a start pulse on its result.
    `DSPMB_ASSERT_NEXT(a_len_start,
        accept && req.kind == dspmb_pkg::KIND_DSP_WR && req.reg_select == dspmb_pkg::DSP_LEN,
        out_valid_reg && rsp_reg.dma_start && !rsp_reg.access_error)
    // A CPU low-half write leaves the inbox flagged full.
    `DSPMB_ASSERT_NEXT(a_inbox_full,
        accept && req.kind == dspmb_pkg::KIND_CPU_WR && req.reg_select == dspmb_pkg::CPU_CMBL,
        inbox_high_reg[dspmb_pkg::DATA_W-1])
    // A stalled result blocks state changes.
    `DSPMB_ASSERT_NEXT(a_stall_hold,
        out_valid_reg && !rsp.ready,
        $stable(outbox_high_reg) && $stable(inbox_high_reg) && $stable(transfer_length_reg))
    // Alignment bits of the DMA registers stay clear.
    `DSPMB_ASSERT_NOW(a_align,
        1'b1,
        local_addr_reg[0] == 1'b0 && main_addr_low_reg[1:0] == 2'b00
        && transfer_length_reg[1:0] == 2'b00)

endmodule
